// File: rtl/pxhex_pkg.sv
package pxhex_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_FLAT_TOPPED = 3'd0;
	localparam logic [2:0] REG_ORIGIN_X    = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd2;
	localparam logic [2:0] REG_INV_SIZE_X  = 3'd3;
	localparam logic [2:0] REG_INV_SIZE_Y  = 3'd4;

	localparam int PIX_W  = 16;
	localparam int DIFF_W = 17;
	localparam int INV_W  = 21;
	localparam int INV_FRAC = 20;
	localparam int HEX_W  = 17;
	localparam int CFG_W  = 21;

	// Scaled pixel offset: 17-bit signed by 21-bit unsigned
	localparam int PROD_W = 38;
	// Split point of the scaled offset for the coefficient products
	localparam int LO_W   = 19;
	localparam int HI_W   = PROD_W - LO_W;

	localparam logic [63:0] C32_TWO_THIRDS  = 64'd2863311531;
	localparam logic [63:0] C32_ONE_THIRD   = 64'd1431655765;
	localparam logic [63:0] C32_SQRT3_THIRD = 64'd2479700525;

	localparam logic [INV_W-1:0] INV_SIZE_ONE = INV_W'(1) << INV_FRAC;

endpackage

// File: rtl/pixel_to_hex_cube_round_unit.sv
// Pixel to cube hex coordinate conversion, eight-stage pipeline.
// Each accepted pixel passes through the stage registers s1 to s8 in order; done is the
// valid bit of the last stage and stays high for one cycle per result.
// Throughput: one pixel per cycle; busy is always low and the receiver cannot stall.
// Each pixel crosses the eight register stages; the coefficient multipliers are split
// into partial products on 19-bit halves of the scaled offset to keep each stage short.
// Reset: arst_n clears the valid bits and loads the register defaults
// (pointy-topped, origin 0, reciprocal sizes 1.0).
module pixel_to_hex_cube_round_unit
	import pxhex_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [2:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [PIX_W-1:0] pixel_x,
	input  logic signed [PIX_W-1:0] pixel_y,
	output logic                    done,
	output logic signed [HEX_W-1:0] hex_q,
	output logic signed [HEX_W-1:0] hex_r,
	output logic signed [HEX_W-1:0] hex_s
);

	localparam int FT   = INV_FRAC + FRAC_BITS;
	localparam int W    = PROD_W + FRAC_BITS + 2;
	localparam int ALO_W = LO_W + FRAC_BITS;
	localparam int AHI_W = HI_W + FRAC_BITS + 1;

	localparam logic [63:0] K23_L = (C32_TWO_THIRDS + (64'd1 << (31 - FRAC_BITS)))
		>> (32 - FRAC_BITS);
	localparam logic [63:0] K13_L = (C32_ONE_THIRD + (64'd1 << (31 - FRAC_BITS)))
		>> (32 - FRAC_BITS);
	localparam logic [63:0] KS3_L = (C32_SQRT3_THIRD + (64'd1 << (31 - FRAC_BITS)))
		>> (32 - FRAC_BITS);
	localparam logic [FRAC_BITS-1:0] K23 = K23_L[FRAC_BITS-1:0];
	localparam logic [FRAC_BITS-1:0] K13 = K13_L[FRAC_BITS-1:0];
	localparam logic [FRAC_BITS-1:0] KS3 = KS3_L[FRAC_BITS-1:0];

	localparam logic signed [W-1:0] HALF_W  = W'(1) << (FT - 1);
	localparam logic [FT:0]         HALF_F  = (FT + 1)'(1) << (FT - 1);
	localparam logic [FT-1:0]       HALF_E  = FT'(1) << (FT - 1);

	// configuration registers
	logic                    flat_q;
	logic signed [PIX_W-1:0] origin_x_q;
	logic signed [PIX_W-1:0] origin_y_q;
	logic [INV_W-1:0]        inv_size_x_q;
	logic [INV_W-1:0]        inv_size_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_q       <= 1'b0;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			inv_size_x_q <= INV_SIZE_ONE;
			inv_size_y_q <= INV_SIZE_ONE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FLAT_TOPPED: flat_q       <= cfg_data[0];
				REG_ORIGIN_X:    origin_x_q   <= cfg_data[PIX_W-1:0];
				REG_ORIGIN_Y:    origin_y_q   <= cfg_data[PIX_W-1:0];
				REG_INV_SIZE_X:  inv_size_x_q <= cfg_data[INV_W-1:0];
				REG_INV_SIZE_Y:  inv_size_y_q <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <=
				{accept, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7};
		end
	end

	// stage 1: offset from origin
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;

	// stage 2: scale by reciprocal size, order the operands for the matrix
	logic signed [PROD_W-1:0] prod_x, prod_y;
	logic signed [PROD_W-1:0] u_s2, w_s2;

	assign prod_x = PROD_W'(dx_s1) * PROD_W'($signed({1'b0, inv_size_x_q}));
	assign prod_y = PROD_W'(dy_s1) * PROD_W'($signed({1'b0, inv_size_y_q}));

	// stage 3: partial products. A = 2/3 u, B = 1/3 u, P = sqrt3/3 w
	logic [ALO_W-1:0]        a_lo_s3, b_lo_s3, p_lo_s3;
	logic signed [AHI_W-1:0] a_hi_s3, b_hi_s3, p_hi_s3;
	logic signed [HI_W-1:0]  u_hi, w_hi;

	assign u_hi = u_s2[PROD_W-1:LO_W];
	assign w_hi = w_s2[PROD_W-1:LO_W];

	// stage 4: assemble A and P - B
	logic signed [W-1:0] a_full, p_full, b_full;
	logic signed [W-1:0] a_s4, pb_s4;

	assign a_full = (W'(a_hi_s3) <<< LO_W) + $signed(W'(a_lo_s3));
	assign b_full = (W'(b_hi_s3) <<< LO_W) + $signed(W'(b_lo_s3));
	assign p_full = (W'(p_hi_s3) <<< LO_W) + $signed(W'(p_lo_s3));

	// stage 5: fractional cube coordinates
	logic signed [W-1:0] fq_s5, fr_s5, fs_s5;

	// stage 6: biased for half-away-from-zero rounding
	logic [W-1:0] tq_s6, tr_s6, ts_s6;
	logic         nq_s6, nr_s6, ns_s6;

	// stage 7: rounded coordinates and their errors
	logic [HEX_W-1:0] rq_s7, rr_s7, rs_s7;
	logic [FT-1:0]    eq_s7, er_s7, es_s7;
	logic [FT:0]      dq, dr, ds;

	assign dq = {1'b0, tq_s6[FT-1:0]} - HALF_F + (FT + 1)'(nq_s6);
	assign dr = {1'b0, tr_s6[FT-1:0]} - HALF_F + (FT + 1)'(nr_s6);
	assign ds = {1'b0, ts_s6[FT-1:0]} - HALF_F + (FT + 1)'(ns_s6);

	// stage 8: recompute the component with the largest error
	logic [HEX_W-1:0] q_s8, r_s8, s_s8;
	logic             fix_q, fix_r;

	assign fix_q = (eq_s7 > er_s7) && (eq_s7 > es_s7);
	assign fix_r = !fix_q && (er_s7 > es_s7);

	always_ff @(posedge clk) begin
		dx_s1 <= {pixel_x[PIX_W-1], pixel_x} - {origin_x_q[PIX_W-1], origin_x_q};
		dy_s1 <= {pixel_y[PIX_W-1], pixel_y} - {origin_y_q[PIX_W-1], origin_y_q};

		u_s2 <= flat_q ? prod_x : prod_y;
		w_s2 <= flat_q ? prod_y : prod_x;

		a_lo_s3 <= ALO_W'(u_s2[LO_W-1:0]) * ALO_W'(K23);
		b_lo_s3 <= ALO_W'(u_s2[LO_W-1:0]) * ALO_W'(K13);
		p_lo_s3 <= ALO_W'(w_s2[LO_W-1:0]) * ALO_W'(KS3);
		a_hi_s3 <= AHI_W'(u_hi) * AHI_W'($signed({1'b0, K23}));
		b_hi_s3 <= AHI_W'(u_hi) * AHI_W'($signed({1'b0, K13}));
		p_hi_s3 <= AHI_W'(w_hi) * AHI_W'($signed({1'b0, KS3}));

		a_s4  <= a_full;
		pb_s4 <= p_full - b_full;

		fq_s5 <= flat_q ? a_s4 : pb_s4;
		fr_s5 <= flat_q ? pb_s4 : a_s4;
		fs_s5 <= -a_s4 - pb_s4;

		// negative values take one ulp off the bias so that ties go away from zero
		tq_s6 <= fq_s5 + HALF_W - W'(fq_s5[W-1]);
		tr_s6 <= fr_s5 + HALF_W - W'(fr_s5[W-1]);
		ts_s6 <= fs_s5 + HALF_W - W'(fs_s5[W-1]);
		nq_s6 <= fq_s5[W-1];
		nr_s6 <= fr_s5[W-1];
		ns_s6 <= fs_s5[W-1];

		rq_s7 <= tq_s6[FT+HEX_W-1:FT];
		rr_s7 <= tr_s6[FT+HEX_W-1:FT];
		rs_s7 <= ts_s6[FT+HEX_W-1:FT];
		eq_s7 <= dq[FT] ? FT'(-dq) : dq[FT-1:0];
		er_s7 <= dr[FT] ? FT'(-dr) : dr[FT-1:0];
		es_s7 <= ds[FT] ? FT'(-ds) : ds[FT-1:0];

		q_s8 <= fix_q ? -rr_s7 - rs_s7 : rq_s7;
		r_s8 <= fix_r ? -rq_s7 - rs_s7 : rr_s7;
		s_s8 <= (fix_q || fix_r) ? rs_s7 : -rq_s7 - rr_s7;
	end

	assign done  = v_s8;
	assign hex_q = q_s8;
	assign hex_r = r_s8;
	assign hex_s = s_s8;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##8 done)
		else $error("accepted pixel did not produce a result after 8 cycles");

	a_cube_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (HEX_W'(hex_q + hex_r + hex_s) == '0))
		else $error("cube coordinates do not sum to zero");

	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> (eq_s7 <= HALF_E) && (er_s7 <= HALF_E) && (es_s7 <= HALF_E))
		else $error("rounding error above one half");

endmodule

// File: tb/tb_pixel_to_hex_cube_round_unit.sv
`timescale 1ns / 100ps

module tb_pixel_to_hex_cube_round_unit;
	import pxhex_pkg::*;

	localparam int FRAC_BITS    = 16;
	localparam int FRAC_TOTAL   = INV_FRAC + FRAC_BITS;
	localparam int PIPE_LATENCY = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 70;

	localparam longint K_TWO_THIRDS =
		longint'((C32_TWO_THIRDS + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
	localparam longint K_ONE_THIRD =
		longint'((C32_ONE_THIRD + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
	localparam longint K_SQRT3_THIRD =
		longint'((C32_SQRT3_THIRD + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

	typedef struct packed {
		logic signed [HEX_W-1:0] q;
		logic signed [HEX_W-1:0] r;
		logic signed [HEX_W-1:0] s;
	} cube_t;

	class hex_scoreboard;
		bit                      flat;
		logic signed [PIX_W-1:0] org_x;
		logic signed [PIX_W-1:0] org_y;
		logic [INV_W-1:0]        inv_x;
		logic [INV_W-1:0]        inv_y;
		cube_t                   pending[$];
		int                      errors;

		function new();
			flat   = 1'b0;
			org_x  = '0;
			org_y  = '0;
			inv_x  = INV_SIZE_ONE;
			inv_y  = INV_SIZE_ONE;
			errors = 0;
		endfunction

		task report(string msg);
			$display("[%0t] ERROR: %s", $realtime, msg);
			errors++;
		endtask

		function void load_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_FLAT_TOPPED: flat  = data[0];
				REG_ORIGIN_X:    org_x = data[PIX_W-1:0];
				REG_ORIGIN_Y:    org_y = data[PIX_W-1:0];
				REG_INV_SIZE_X:  inv_x = data[INV_W-1:0];
				REG_INV_SIZE_Y:  inv_y = data[INV_W-1:0];
				default: ;
			endcase
		endfunction

		// Round half away from zero, returning the absolute rounding error too
		function longint round_away(longint v, output longint unsigned err);
			longint unsigned one;
			longint unsigned mag;
			longint unsigned frac;
			longint unsigned whole;
			one   = 64'd1 << FRAC_TOTAL;
			mag   = (v < 0) ? longint'(-v) : longint'(v);
			frac  = mag & (one - 64'd1);
			whole = mag >> FRAC_TOTAL;
			if (frac >= (one >> 1)) begin
				whole += 64'd1;
				err = one - frac;
			end else begin
				err = frac;
			end
			return (v < 0) ? -longint'(whole) : longint'(whole);
		endfunction

		function cube_t cube_of_pixel(logic signed [PIX_W-1:0] x, logic signed [PIX_W-1:0] y);
			longint dx, dy, sx, sy, fq, fr, fs, q, r, s;
			longint unsigned eq, er, es;
			cube_t res;
			dx = longint'(x) - longint'(org_x);
			dy = longint'(y) - longint'(org_y);
			sx = dx * longint'(inv_x);
			sy = dy * longint'(inv_y);
			if (flat) begin
				fq = K_TWO_THIRDS * sx;
				fr = K_SQRT3_THIRD * sy - K_ONE_THIRD * sx;
			end else begin
				fq = K_SQRT3_THIRD * sx - K_ONE_THIRD * sy;
				fr = K_TWO_THIRDS * sy;
			end
			fs = -fq - fr;
			q = round_away(fq, eq);
			r = round_away(fr, er);
			s = round_away(fs, es);
			// Rebuild the coordinate with the worst error; strict compares decide ties
			if (eq > er && eq > es)
				q = -r - s;
			else if (er > es)
				r = -q - s;
			else
				s = -q - r;
			res.q = q[HEX_W-1:0];
			res.r = r[HEX_W-1:0];
			res.s = s[HEX_W-1:0];
			return res;
		endfunction

		function void note_pixel(logic signed [PIX_W-1:0] x, logic signed [PIX_W-1:0] y);
			pending.push_back(cube_of_pixel(x, y));
		endfunction

		task check(cube_t got);
			cube_t want;
			if (pending.size() == 0) begin
				report($sformatf("result (%0d, %0d, %0d) with no transfer outstanding",
					got.q, got.r, got.s));
				return;
			end
			want = pending.pop_front();
			if (got.q !== want.q)
				report($sformatf("hex_q got %0d expected %0d", got.q, want.q));
			if (got.r !== want.r)
				report($sformatf("hex_r got %0d expected %0d", got.r, want.r));
			if (got.s !== want.s)
				report($sformatf("hex_s got %0d expected %0d", got.s, want.s));
		endtask
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_write = 1'b0;
	logic [2:0]              cfg_index = REG_FLAT_TOPPED;
	logic [CFG_W-1:0]        cfg_data  = '0;
	logic                    start     = 1'b0;
	logic                    busy;
	logic signed [PIX_W-1:0] pixel_x   = '0;
	logic signed [PIX_W-1:0] pixel_y   = '0;
	logic                    done;
	logic signed [HEX_W-1:0] hex_q;
	logic signed [HEX_W-1:0] hex_r;
	logic signed [HEX_W-1:0] hex_s;

	hex_scoreboard           sb = new();
	int                      cycle_count = 0;
	logic signed [PIX_W-1:0] cur_org_x = '0;
	logic signed [PIX_W-1:0] cur_org_y = '0;

	pixel_to_hex_cube_round_unit #(
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.start    (start),
		.busy     (busy),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.done     (done),
		.hex_q    (hex_q),
		.hex_r    (hex_r),
		.hex_s    (hex_s)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_write)
				sb.load_reg(cfg_index, cfg_data);
			if (start && !busy)
				sb.note_pixel(pixel_x, pixel_y);
			if (done)
				sb.check('{q: hex_q, r: hex_r, s: hex_s});
		end
	end

	task automatic cfg_write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Present one pixel and hold it until the transfer
	task automatic send_pixel(logic signed [PIX_W-1:0] x, logic signed [PIX_W-1:0] y);
		@(negedge clk);
		start   <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			@(negedge clk);
			start   <= 1'b0;
			pixel_x <= PIX_W'($urandom());
			pixel_y <= PIX_W'($urandom());
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		pause(1);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic send_list(logic [2*PIX_W-1:0] pts[$]);
		foreach (pts[i])
			send_pixel(pts[i][2*PIX_W-1:PIX_W], pts[i][PIX_W-1:0]);
	endtask

	task automatic setup(bit flat, logic signed [PIX_W-1:0] ox, logic signed [PIX_W-1:0] oy,
			logic [INV_W-1:0] ix, logic [INV_W-1:0] iy);
		logic [CFG_W-1:0] data;
		// Junk in the unused upper bits must be ignored
		data    = CFG_W'($urandom());
		data[0] = flat;
		cfg_write_reg(REG_FLAT_TOPPED, data);
		data = CFG_W'($urandom());
		data[PIX_W-1:0] = ox;
		cfg_write_reg(REG_ORIGIN_X, data);
		data = CFG_W'($urandom());
		data[PIX_W-1:0] = oy;
		cfg_write_reg(REG_ORIGIN_Y, data);
		cfg_write_reg(REG_INV_SIZE_X, ix);
		cfg_write_reg(REG_INV_SIZE_Y, iy);
		cur_org_x = ox;
		cur_org_y = oy;
	endtask

	function automatic logic [INV_W-1:0] pick_inv();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return INV_W'(1);
			2:       return INV_SIZE_ONE;
			3:       return '1;
			4:       return INV_W'($urandom());
			default: return INV_SIZE_ONE / INV_W'($urandom_range(2, 100));
		endcase
	endfunction

	function automatic logic signed [PIX_W-1:0] pick_origin();
		case ($urandom_range(0, 5))
			0:       return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
			1:       return PIX_W'($urandom());
			default: return PIX_W'($urandom_range(0, 2000)) - 16'sd1000;
		endcase
	endfunction

	// Mostly near the origin, where hex boundaries are dense; some anywhere
	function automatic logic signed [PIX_W-1:0] pick_coord(logic signed [PIX_W-1:0] org);
		case ($urandom_range(0, 9))
			7, 8:    return PIX_W'($urandom());
			9: begin
				case ($urandom_range(0, 3))
					0:       return 16'sh8000;
					1:       return 16'sh7fff;
					2:       return 16'sh0000;
					default: return 16'shffff;
				endcase
			end
			default: return org + PIX_W'($urandom_range(0, 400)) - 16'sd200;
		endcase
	endfunction

	function automatic int pick_gap(bit gappy);
		int roll;
		roll = $urandom_range(0, 99);
		if (!gappy || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		logic [2*PIX_W-1:0] pts[$];
		bit gappy;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: pointy-topped, origin 0, unit scale. Corner pixels and
		// the exact half tie on q from x = -32768.
		pts = '{ {16'sh0000, 16'sh0000}, {16'sh8000, 16'sh0000}, {16'sh7fff, 16'sh0000},
			{16'sh0000, 16'sh8000}, {16'sh0000, 16'sh7fff}, {16'sh8000, 16'sh8000},
			{16'sh7fff, 16'sh7fff}, {16'sh8000, 16'sh7fff}, {16'sh7fff, 16'sh8000},
			{16'sh0001, 16'sh0000}, {16'sh0000, 16'sh0001}, {16'shffff, 16'shffff} };
		send_list(pts);
		drain();

		// Flat-topped, origin shifted so that dx reaches +32768 (the other tie)
		setup(1'b1, -16'sd1, -16'sd1, INV_SIZE_ONE, INV_SIZE_ONE);
		pts = '{ {16'sh7fff, 16'sh7fff}, {16'sh8000, 16'sh8000}, {16'shffff, 16'shffff},
			{16'sh0000, 16'sh0000}, {16'sh7fff, 16'sh8000}, {16'sh8000, 16'sh7fff},
			{16'sh0001, 16'shfffe} };
		send_list(pts);
		drain();

		// An unmapped register index must change nothing
		cfg_write_reg(REG_INV_SIZE_Y + 3'd1, '1);
		pts = '{ {16'sh0005, 16'shfff7}, {16'sh7fff, 16'sh0000} };
		send_list(pts);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0:       setup(1'b1, 16'sh8000, 16'sh7fff, '1, '0);
				1:       setup(1'b0, 16'sh7fff, 16'sh8000, '0, '1);
				2:       setup(1'($urandom()), pick_origin(), pick_origin(), INV_W'(1), INV_W'(1));
				default: setup(1'($urandom()), pick_origin(), pick_origin(), pick_inv(), pick_inv());
			endcase
			gappy = ($urandom_range(0, 9) < 7);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_pixel(pick_coord(cur_org_x), pick_coord(cur_org_y));
				pause(pick_gap(gappy));
			end
			drain();
		end

		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending.size()));
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
